// ===== rtl/core/sst_pkg.sv =====
`default_nettype none
package sst_pkg;

  localparam int unsigned Slots     = 16;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned CntW      = $clog2(Slots + 1);
  localparam int unsigned StateW    = 3;
  localparam int unsigned StrideW   = 32;
  localparam int unsigned PrioW     = 10;
  localparam int unsigned BaseW     = 21;
  localparam int unsigned IdW       = 16;
  localparam int unsigned DivCntW   = $clog2(BaseW + 1);

  localparam logic [BaseW-1:0] BaseReset  = 21'd65536;
  localparam logic [PrioW-1:0] PrioReset  = 10'd16;
  localparam logic [PrioW-1:0] PrioMin    = 10'd2;

  // actions
  localparam logic [1:0] ActAlloc = 2'd0;
  localparam logic [1:0] ActState = 2'd1;
  localparam logic [1:0] ActPrio  = 2'd2;
  localparam logic [1:0] ActPick  = 2'd3;

  // slot lifecycle
  localparam logic [StateW-1:0] StUnused   = 3'd0;
  localparam logic [StateW-1:0] StUsed     = 3'd1;
  localparam logic [StateW-1:0] StRunnable = 3'd2;
  localparam logic [StateW-1:0] StRunning  = 3'd3;
  localparam logic [StateW-1:0] StZombie   = 3'd4;

  // result status
  localparam logic [1:0] StsDone    = 2'd0;
  localparam logic [1:0] StsNone    = 2'd1;
  localparam logic [1:0] StsBadPrio = 2'd2;

  // divider handshake
  typedef struct packed {
    logic             start;
    logic [BaseW-1:0] dividend;
    logic [PrioW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [BaseW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/sst_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module sst_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sst_pkg::div_req_t req_i,
  output sst_pkg::div_rsp_t      rsp_o
);
  import sst_pkg::*;

  logic [BaseW-1:0]   quo_q, quo_d;
  logic [PrioW-1:0]   rem_q, rem_d;
  logic [PrioW-1:0]   dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [PrioW:0]     trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[BaseW-1]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = (req_i.divisor == '0) ? PrioW'(1) : req_i.divisor;
      cnt_d  = DivCntW'(BaseW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = PrioW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[BaseW-2:0], 1'b1};
      end else begin
        rem_d = trial[PrioW-1:0];
        quo_d = {quo_q[BaseW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/stride_scheduler_table.sv =====
`default_nettype none
// Stride scheduler task table.
// Input stream (s_axis_*): one word per command: action, slot, new_state,
// new_priority. Output stream (m_axis_*): one word per command: status,
// chosen_slot, task_id. APB port: register 0 is step_base at address 0.
// Slot state, stride and priority live in one synchronous memory with a
// registered read; the per-slot valid bits (in flops) make a never-written
// row read as its reset value, so no clearing pass is needed.
// Commands run one at a time. Set state / set priority: read the row, write
// it back, load the result, then take the next word.
// Allocate and pick scan the table one row per cycle: allocate, or a pick
// that finds nothing runnable, then gives its result. A pick that finds a
// slot adds a bit-serial divide and a write-back before its result.
// Reset empties the table (all rows unused, stride 0, priority 16),
// sets the id counter to 1 and step_base to 65536.
// A result waits in the output register while m_axis_tready is low; the
// next command still runs, then holds in its result state until the
// waiting word is taken.
module stride_scheduler_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] action, [5:2] slot, [8:6] new_state, [18:9] new_priority
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [5:2] chosen_slot, [21:6] task_id
  output logic [23:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sst_pkg::*;

  localparam int unsigned RowW = StateW + StrideW + PrioW;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRd    = 4'd1;
  localparam logic [3:0] SWr    = 4'd2;
  localparam logic [3:0] SScan  = 4'd3;
  localparam logic [3:0] SFound = 4'd4;
  localparam logic [3:0] SDiv   = 4'd5;
  localparam logic [3:0] SOut   = 4'd6;
  localparam logic [3:0] SPick  = 4'd7;

  // ---- memory ----
  logic [RowW-1:0]  mem [Slots];
  logic [Slots-1:0] vld_q;
  logic             we;
  logic [SlotW-1:0] waddr, raddr;
  logic [RowW-1:0]  wdata, rdata_q, row;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we) vld_q[waddr] <= 1'b1;
      rvld_q <= vld_q[raddr] | (we && waddr == raddr);
    end
  end

  // no bypass of a same-cycle write is needed: the row read in a state that
  // writes is never used; only the valid bit tracks the pending write
  assign row = rvld_q ? rdata_q : {StUnused, {StrideW{1'b0}}, PrioReset};

  logic [StateW-1:0]  r_state;
  logic [StrideW-1:0] r_stride;
  logic [PrioW-1:0]   r_prio;
  assign {r_state, r_stride, r_prio} = row;

  // ---- control ----
  logic [3:0]       st_q, st_d;
  logic [1:0]       act_q;
  logic [SlotW-1:0] slot_q, idx_q, idx_d, best_q, best_d;
  logic [StateW-1:0] nst_q;
  logic [PrioW-1:0] nprio_q, bprio_q, bprio_d;
  logic [StrideW-1:0] bstr_q, bstr_d;
  logic             found_q, found_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdW-1:0]   nid_q, nid_d;
  logic [BaseW-1:0] base_q;
  logic [1:0]       sts_q, sts_d;
  logic [3:0]       cs_q, cs_d;
  logic [IdW-1:0]   tid_q, tid_d;
  logic             ov_q, ov_d;
  logic [21:0]      res_q, res_d;
  div_req_t         dreq;
  div_rsp_t         drsp;
  logic             acc;
  logic [3:0]       slot_in;

  sst_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == SIdle);
  assign slot_in  = s_axis_tdata[5:2];

  always_comb begin
    st_d    = st_q;
    idx_d   = idx_q;
    best_d  = best_q;
    bstr_d  = bstr_q;
    bprio_d = bprio_q;
    found_d = found_q;
    cnt_d   = cnt_q;
    nid_d   = nid_q;
    sts_d   = sts_q;
    cs_d    = cs_q;
    tid_d   = tid_q;
    ov_d    = ov_q;
    res_d   = res_q;
    raddr   = idx_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = row;
    dreq.start    = 1'b0;
    dreq.dividend = base_q;
    dreq.divisor  = bprio_q;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (st_q)
      SIdle: begin
        if (acc) begin
          idx_d = '0;
          raddr = '0;
          cnt_d = '0;
          found_d = 1'b0;
          if (s_axis_tdata[1:0] == ActAlloc || s_axis_tdata[1:0] == ActPick) begin
            st_d = SScan;
          end else begin
            idx_d = SlotW'(slot_in);
            raddr = SlotW'(slot_in);
            st_d  = SRd;
          end
        end
      end
      SRd: begin
        st_d = SWr;
      end
      SWr: begin
        sts_d = StsDone;
        cs_d  = '0;
        tid_d = '0;
        if (act_q == ActState) begin
          if (32'(slot_q) < Slots && nst_q <= StZombie) begin
            we = 1'b1;
            wdata = {nst_q, r_stride, r_prio};
          end
        end else if (nprio_q < PrioMin) begin
          sts_d = StsBadPrio;
        end else if (32'(slot_q) < Slots) begin
          we = 1'b1;
          wdata = {r_state, r_stride, nprio_q};
        end
        st_d = SOut;
      end
      SScan: begin
        // issue the read of row 0; from here on the row examined in
        // SFound is always idx_q - 1
        raddr = idx_q;
        idx_d = idx_q + SlotW'(1);
        st_d  = SFound;
      end
      SFound: begin
        // examine the row read last cycle (index idx_q - 1)
        raddr = idx_q;
        idx_d = idx_q + SlotW'(1);
        cnt_d = cnt_q + CntW'(1);
        if (act_q == ActAlloc) begin
          if (!found_q && r_state == StUnused) begin
            found_d = 1'b1;
            best_d  = idx_q - SlotW'(1);
          end
        end else if (r_state == StRunnable &&
                     (!found_q || r_stride < bstr_q)) begin
          found_d = 1'b1;
          best_d  = idx_q - SlotW'(1);
          bstr_d  = r_stride;
          bprio_d = r_prio;
        end
        if (cnt_q == CntW'(Slots - 1)) st_d = SPick;
      end
      SPick: begin
        cs_d  = '0;
        tid_d = '0;
        if (!found_q) begin
          sts_d = StsNone;
          st_d  = SOut;
        end else if (act_q == ActAlloc) begin
          we    = 1'b1;
          waddr = best_q;
          wdata = {StUsed, {StrideW{1'b0}}, PrioReset};
          sts_d = StsDone;
          cs_d  = 4'(best_q);
          tid_d = nid_q;
          nid_d = nid_q + IdW'(1);
          st_d  = SOut;
        end else begin
          dreq.start = 1'b1;
          st_d = SDiv;
        end
      end
      SDiv: begin
        if (drsp.done) begin
          we    = 1'b1;
          waddr = best_q;
          wdata = {StRunning, bstr_q + StrideW'(drsp.quotient), bprio_q};
          sts_d = StsDone;
          cs_d  = 4'(best_q);
          tid_d = '0;
          st_d  = SOut;
        end
      end
      SOut: begin
        // load the output register once it is free or being taken
        if (!ov_q || m_axis_tready) begin
          ov_d  = 1'b1;
          res_d = {tid_q, cs_q, sts_q};
          st_d  = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SIdle;
      found_q <= 1'b0;
      cnt_q   <= '0;
      nid_q   <= IdW'(1);
      ov_q    <= 1'b0;
      base_q  <= BaseReset;
    end else begin
      st_q    <= st_d;
      found_q <= found_d;
      cnt_q   <= cnt_d;
      nid_q   <= nid_d;
      ov_q    <= ov_d;
      if (psel && penable && pwrite && pready && paddr == 2'd0)
        base_q <= pwdata[BaseW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    best_q  <= best_d;
    bstr_q  <= bstr_d;
    bprio_q <= bprio_d;
    sts_q   <= sts_d;
    cs_q    <= cs_d;
    tid_q   <= tid_d;
    res_q   <= res_d;
    if (acc) begin
      act_q   <= s_axis_tdata[1:0];
      slot_q  <= SlotW'(slot_in);
      nst_q   <= s_axis_tdata[8:6];
      nprio_q <= s_axis_tdata[18:9];
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, res_q};
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{(32-BaseW){1'b0}}, base_q} : 32'd0;

  // ---- checks ----
  a_one_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(st_q == SDiv)) else $error("accept during divide");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> st_q == SDiv) else $error("stray divide done");
endmodule
`default_nettype wire
